### design/bfdo_pkg.sv
// Shared types and constants for the bounded drop-oldest queue.
// No dependencies; used by bounded_fifo_drop_oldest, bfdo_checker and the testbench.
package bfdo_pkg;

  // Command codes carried by one input beat.
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  // Configuration register map.
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int LIMIT_W       = 9;
  localparam int REG_IDX_MAX   = 0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // Fixed field widths of the command and result beats.
  localparam int PAYLOAD_W = 32;

  // Status codes of a result beat.
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

### design/bfdo_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
module bfdo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bounded_fifo_drop_oldest.sv
// Bounded FIFO that discards its oldest entry when a push exceeds the limit.
// A command's result beat appears in the cycle after it is accepted.
// Throughput: one command per cycle; busy stays low, as each command reads or
// writes the entry RAM once and the pointer and count registers settle at once.
// Reset (synchronous, rst_n low) clears head, tail and count and sets the limit
// to 256; the entry RAM is not cleared. The result receiver cannot stall.
module bounded_fifo_drop_oldest #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [bfdo_pkg::PAYLOAD_W-1:0]      in_payload,
  // Result channel
  output logic                                out_valid,
  output logic                                out_status,
  output logic [bfdo_pkg::PAYLOAD_W-1:0]      out_head_payload,
  output logic                                out_dropped,
  output logic [$clog2(DEPTH + 1)-1:0]        out_fill_count,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfdo_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bfdo_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bfdo_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LIM_W = (CNT_W > bfdo_pkg::LIMIT_W) ? CNT_W : bfdo_pkg::LIMIT_W;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [LIM_W-1:0] LIM_DEPTH = LIM_W'(DEPTH);

  // Queue state
  logic [PTR_W-1:0]               head_r, head_nxt;
  logic [PTR_W-1:0]               tail_r, tail_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [bfdo_pkg::LIMIT_W-1:0]   limit_r;

  // Result registers
  logic                           out_valid_r;
  logic                           status_r, status_nxt;
  logic                           dropped_r, dropped_nxt;
  logic                           use_rd_r, use_rd_nxt;
  logic [CNT_W-1:0]               fill_r;

  // RAM access
  logic                           ram_we, ram_re;
  logic [DATA_WIDTH-1:0]          ram_wdata, ram_rdata;

  logic                           accept;
  logic                           cfg_wr;
  logic                           reg_sel;
  bfdo_pkg::cmd_t                 cmd;
  logic [LIM_W-1:0]               limit_raw;
  logic [LIM_W-1:0]               limit_eff;
  logic [PTR_W-1:0]               head_inc, tail_inc;
  logic [bfdo_pkg::PAYLOAD_W-1:0] head_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = bfdo_pkg::cmd_t'(in_cmd);

  // Configuration port: zero-wait writes and reads of the limit register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[bfdo_pkg::CFG_ADDR_W-1:2] == 1'(bfdo_pkg::REG_IDX_MAX));
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? bfdo_pkg::CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= bfdo_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[bfdo_pkg::LIMIT_W-1:0];
    end
  end

  // Effective limit: zero or anything above the ring depth means the full ring.
  assign limit_raw = LIM_W'(limit_r);
  assign limit_eff = (limit_raw == '0 || limit_raw > LIM_DEPTH) ? LIM_DEPTH : limit_raw;

  // Ring pointer increments with wrap.
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);

  // Stored word is the payload fitted to the RAM width.
  generate
    if (DATA_WIDTH <= bfdo_pkg::PAYLOAD_W) begin : g_narrow
      assign ram_wdata = in_payload[DATA_WIDTH-1:0];
      assign head_word = bfdo_pkg::PAYLOAD_W'(ram_rdata);
    end else begin : g_wide
      assign ram_wdata = DATA_WIDTH'(in_payload);
      assign head_word = ram_rdata[bfdo_pkg::PAYLOAD_W-1:0];
    end
  endgenerate

  // Command decode: pointer and count updates, RAM access and result flags.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    status_nxt  = bfdo_pkg::STATUS_DONE;
    dropped_nxt = 1'b0;
    use_rd_nxt  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (accept) begin
      case (cmd)
        bfdo_pkg::CMD_PUSH: begin
          ram_we   = 1'b1;
          tail_nxt = tail_inc;
          if (count_r == CNT_FULL) begin
            // Ring full: the new word took the oldest slot.
            head_nxt    = head_inc;
            dropped_nxt = 1'b1;
          end else if (LIM_W'(count_r) + LIM_W'(1) > limit_eff) begin
            // Over the limit: drop the oldest, count stays put.
            head_nxt    = head_inc;
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bfdo_pkg::CMD_POP, bfdo_pkg::CMD_PEEK: begin
          if (count_r == '0) begin
            status_nxt = bfdo_pkg::STATUS_EMPTY;
          end else begin
            ram_re     = 1'b1;
            use_rd_nxt = 1'b1;
            if (cmd == bfdo_pkg::CMD_POP) begin
              head_nxt  = head_inc;
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        default: begin
          // Unused command: no change, report the current count.
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      dropped_r <= dropped_nxt;
      use_rd_r  <= use_rd_nxt;
      fill_r    <= count_nxt;
    end
  end

  // Entry storage
  bfdo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Result beat outputs
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_dropped      = dropped_r;
  assign out_fill_count   = fill_r;
  assign out_head_payload = use_rd_r ? head_word : '0;

  // The count never exceeds the ring depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_FULL)
    else $error("entry count above ring depth");

  // Every accepted command yields exactly one result beat in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
    else $error("result beat missing after accepted command");

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> $past(accept))
    else $error("result beat without a command");

  // An empty report never carries a word or a drop.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_status) |-> (out_head_payload == '0 && !out_dropped))
    else $error("empty report carries data");

endmodule

### test/bfdo_checker.sv
`timescale 1ns / 100ps
// Checker for the bounded drop-oldest queue: watches the command, result and APB ports.
// It predicts each result beat from its own ring model and compares field by field.
// Depends on bfdo_pkg for the command codes, widths and the reset limit.
module bfdo_checker #(
  parameter int                                DEPTH      = 256,
  parameter int                                CNT_W      = $clog2(DEPTH + 1),
  parameter logic [bfdo_pkg::CFG_ADDR_W-1:0]   LIMIT_ADDR = '0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [bfdo_pkg::PAYLOAD_W-1:0]      in_payload,
  input  logic                                out_valid,
  input  logic                                out_status,
  input  logic [bfdo_pkg::PAYLOAD_W-1:0]      out_head_payload,
  input  logic                                out_dropped,
  input  logic [CNT_W-1:0]                    out_fill_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfdo_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bfdo_pkg::CFG_DATA_W-1:0]     pwdata,
  input  logic                                pready,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam int PTR_W = $clog2(DEPTH);

  typedef struct packed {
    logic                           status;
    logic [bfdo_pkg::PAYLOAD_W-1:0] head_payload;
    logic                           dropped;
    logic [CNT_W-1:0]               fill_count;
  } queue_result_t;

  // Shadow copy of the queue and its limit register.
  logic [bfdo_pkg::PAYLOAD_W-1:0] entry_ram [DEPTH];
  logic [PTR_W-1:0]               head_ptr;
  logic [PTR_W-1:0]               tail_ptr;
  logic [CNT_W-1:0]               fill;
  logic [bfdo_pkg::LIMIT_W-1:0]   limit_reg;
  queue_result_t                  awaited_results [$];

  function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Applies one command to the shadow queue and returns the result beat it should give.
  task automatic predict_queue_op(input logic [1:0] cmd,
                                  input logic [bfdo_pkg::PAYLOAD_W-1:0] word,
                                  output queue_result_t res);
    int unsigned cap;
    res = '0;
    res.status = bfdo_pkg::STATUS_DONE;
    // A limit of zero, or one beyond the ring, means the whole ring.
    cap = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
    case (cmd)
      bfdo_pkg::CMD_PUSH: begin
        entry_ram[tail_ptr] = word;
        tail_ptr = ring_step(tail_ptr);
        if (fill >= DEPTH) begin
          // The ring is full, so the new word has overwritten the oldest slot.
          head_ptr = ring_step(head_ptr);
          res.dropped = 1'b1;
        end else begin
          fill = fill + 1'b1;
          if (fill > cap) begin
            head_ptr = ring_step(head_ptr);
            fill = fill - 1'b1;
            res.dropped = 1'b1;
          end
        end
      end
      bfdo_pkg::CMD_POP, bfdo_pkg::CMD_PEEK: begin
        if (fill == 0) begin
          res.status = bfdo_pkg::STATUS_EMPTY;
        end else begin
          res.head_payload = entry_ram[head_ptr];
          if (cmd == bfdo_pkg::CMD_POP) begin
            head_ptr = ring_step(head_ptr);
            fill = fill - 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.fill_count = fill;
  endtask

  function automatic bit field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Track configuration writes and accepted commands, then check each result beat.
  always @(posedge clk) begin
    queue_result_t predicted;
    if (!rst_n) begin
      head_ptr = '0;
      tail_ptr = '0;
      fill = '0;
      limit_reg = bfdo_pkg::LIMIT_RESET;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
        limit_reg = pwdata[bfdo_pkg::LIMIT_W-1:0];
      end
      if (start && !busy) begin
        predict_queue_op(in_cmd, in_payload, predicted);
        awaited_results.push_back(predicted);
      end
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          mismatches++;
        end else begin
          predicted = awaited_results.pop_front();
          if (field_differs("status", predicted.status, out_status)) mismatches++;
          if (field_differs("head_payload", predicted.head_payload, out_head_payload))
            mismatches++;
          if (field_differs("dropped", predicted.dropped, out_dropped)) mismatches++;
          if (field_differs("fill_count", predicted.fill_count, out_fill_count)) mismatches++;
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

### test/tb_bounded_fifo_drop_oldest.sv
`timescale 1ns / 100ps
// Testbench top for bounded_fifo_drop_oldest: clock, reset, command and APB stimulus.
// Relies on bfdo_checker for prediction and comparison, and on bfdo_pkg for codes.
module tb_bounded_fifo_drop_oldest;

  localparam int                              DEPTH          = 256;
  localparam int                              CNT_W          = $clog2(DEPTH + 1);
  localparam logic [bfdo_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR     = '0;
  localparam logic [1:0]                      CMD_UNUSED     = 2'd3;
  localparam int                              WATCHDOG_LIMIT = 200;
  localparam int                              DRAIN_LIMIT    = 100;
  localparam int                              NUM_PHASES     = 9;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [1:0]                      in_cmd;
  logic [bfdo_pkg::PAYLOAD_W-1:0]  in_payload;
  logic                            out_valid;
  logic                            out_status;
  logic [bfdo_pkg::PAYLOAD_W-1:0]  out_head_payload;
  logic                            out_dropped;
  logic [CNT_W-1:0]                out_fill_count;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [bfdo_pkg::CFG_ADDR_W-1:0] paddr;
  logic [bfdo_pkg::CFG_DATA_W-1:0] pwdata;
  logic [bfdo_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  int                              mismatch_count;
  int                              results_pending;
  int                              idle_cycles;
  int unsigned                     burst_left;

  bounded_fifo_drop_oldest #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (bfdo_pkg::PAYLOAD_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_payload (out_head_payload),
    .out_dropped      (out_dropped),
    .out_fill_count   (out_fill_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  bfdo_checker #(
    .DEPTH      (DEPTH),
    .LIMIT_ADDR (LIMIT_ADDR)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_payload (out_head_payload),
    .out_dropped      (out_dropped),
    .out_fill_count   (out_fill_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatches       (mismatch_count),
    .outstanding      (results_pending)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap before the next command beat: usually a random draw, with bursts of none.
  function automatic int unsigned draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(19) == 0) begin
      burst_left = $urandom_range(40, 10);
      return 0;
    end
    return $urandom_range(10);
  endfunction

  function automatic logic [1:0] pick_command(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return bfdo_pkg::CMD_PUSH;
    roll = $urandom_range(99);
    if (roll < 70) return bfdo_pkg::CMD_POP;
    if (roll < 95) return bfdo_pkg::CMD_PEEK;
    return CMD_UNUSED;
  endfunction

  function automatic logic [bfdo_pkg::PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Drives one command beat after a random gap and holds it until accepted.
  task automatic send_command(input logic [1:0] cmd,
                              input logic [bfdo_pkg::PAYLOAD_W-1:0] word);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_cmd = cmd;
    in_payload = word;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the command channel off until every outstanding result beat has come.
  task automatic drain_results();
    start = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // Writes the limit register once the queue logic is idle.
  task automatic write_limit(input logic [bfdo_pkg::LIMIT_W-1:0] value);
    drain_results();
    // The block answers in the cycle after acceptance; leave a little margin.
    repeat (2) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = LIMIT_ADDR;
    pwdata = {{(bfdo_pkg::CFG_DATA_W - bfdo_pkg::LIMIT_W){1'b0}}, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int unsigned phase_limit [NUM_PHASES];
    int unsigned phase_items [NUM_PHASES];
    int unsigned phase_push_pct [NUM_PHASES];
    int          waited;

    phase_limit    = '{1, 2, 0, 255, 511, 257, 3, 0, 256};
    phase_items    = '{100, 100, 350, 100, 300, 150, 150, 150, 200};
    phase_push_pct = '{60, 50, 85, 30, 80, 20, 50, 55, 50};
    phase_limit[7] = $urandom_range(511, 1);
    waited = 0;
    burst_left = 0;
    idle_cycles = 0;

    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = bfdo_pkg::CMD_PUSH;
    in_payload = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty reads, the unused code, payload extremes and a limit of one.
    send_command(bfdo_pkg::CMD_PEEK, '1);
    send_command(bfdo_pkg::CMD_POP, '1);
    send_command(CMD_UNUSED, '1);
    send_command(bfdo_pkg::CMD_PUSH, '0);
    send_command(bfdo_pkg::CMD_PUSH, '1);
    send_command(bfdo_pkg::CMD_PUSH, 32'h8000_0001);
    send_command(bfdo_pkg::CMD_PEEK, '0);
    send_command(CMD_UNUSED, '0);
    send_command(bfdo_pkg::CMD_POP, '0);
    send_command(bfdo_pkg::CMD_POP, '0);
    send_command(bfdo_pkg::CMD_POP, '0);
    send_command(bfdo_pkg::CMD_POP, '0);
    write_limit(9'd1);
    send_command(bfdo_pkg::CMD_PUSH, 32'h1234_5678);
    send_command(bfdo_pkg::CMD_PUSH, 32'hfedc_ba98);
    send_command(bfdo_pkg::CMD_PEEK, '0);
    send_command(bfdo_pkg::CMD_POP, '0);
    send_command(bfdo_pkg::CMD_POP, '0);
    // Raising the limit to the full ring, then lowering it with entries still queued.
    write_limit(9'd0);
    send_command(bfdo_pkg::CMD_PUSH, 32'h0000_00aa);
    send_command(bfdo_pkg::CMD_PUSH, 32'h0000_00bb);
    send_command(bfdo_pkg::CMD_PUSH, 32'h0000_00cc);
    write_limit(9'd1);
    send_command(bfdo_pkg::CMD_PUSH, 32'h0000_00dd);
    send_command(bfdo_pkg::CMD_POP, '0);
    send_command(bfdo_pkg::CMD_POP, '0);

    // Random phases, each under its own limit; push-heavy phases fill the whole ring.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p][bfdo_pkg::LIMIT_W-1:0]);
      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(99) == 0) drain_results();
        send_command(pick_command(phase_push_pct[p]), pick_payload());
      end
    end

    // Let the last result beats arrive, then give the verdict.
    start = 1'b0;
    while (results_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
